FILE: sv/omss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omss_pkg
// Shared constants and types for the ordered merge block.
// ----------------------------------------------------------------------------
package omss_pkg;

  localparam int unsigned Sources    = 8;
  localparam int unsigned QueueDepth = 32;
  localparam int unsigned MaxResults = 32;

  localparam int unsigned ValW   = 31;
  localparam int unsigned SrcW   = 3;
  localparam int unsigned CfgW   = 4;
  localparam int unsigned AddrW  = $clog2(QueueDepth);
  localparam int unsigned OccW   = $clog2(QueueDepth + 1);
  localparam int unsigned CntW   = 6;
  localparam int unsigned RelW   = $clog2(MaxResults + 1);
  localparam int unsigned EntryW = ValW + SrcW;

  localparam logic ActPush   = 1'b0;
  localparam logic ActFinish = 1'b1;

  typedef struct packed {
    logic [SrcW-1:0] src;
    logic [ValW-1:0] val;
  } entry_t;

  // a wins over b: smaller value, ties to the higher source
  function automatic logic entry_better(entry_t a, entry_t b);
    return (a.val < b.val) || ((a.val == b.val) && (a.src > b.src));
  endfunction

endpackage

FILE: sv/omss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omss_ram
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module omss_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 34
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: sv/ordered_merge_of_sorted_sources.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_merge_of_sorted_sources
// Merges ascending streams of up to eight sources into one ascending stream.
// ----------------------------------------------------------------------------
// Pending values live in one 32-entry memory, unsorted. An input item that
// releases nothing passes through accept, check and status. When release
// runs, each released value takes a scan that reads the occupied entries one
// per cycle, waits out the read latency and reads the tail entry; a pop step
// and an emit step follow. The minimum search over the memory port sets the
// rate. Each result waits in an output register until taken, and a stalled
// output adds its stall cycles. No clearing pass is needed after reset.
module ordered_merge_of_sorted_sources (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [omss_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [omss_pkg::SrcW-1:0]     source_i,
  input  logic [omss_pkg::ValW-1:0]     value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          value_valid_o,
  output logic [omss_pkg::ValW-1:0]     released_value_o,
  output logic [omss_pkg::SrcW-1:0]     released_source_o,
  output logic                          last_o,
  output logic                          queue_empty_o,
  output logic                          dropped_o
);

  typedef enum logic [2:0] {
    StIdle, StCheck, StScan, StPop, StEmit, StStatus
  } state_e;

  state_e state_q;
  logic [omss_pkg::CfgW-1:0] active_q;
  logic [omss_pkg::OccW-1:0] occ_q;
  logic [omss_pkg::CntW-1:0] pend_q [omss_pkg::Sources];
  logic [omss_pkg::Sources-1:0] fin_q;
  logic dropped_q;
  logic [omss_pkg::RelW-1:0] nrel_q;

  // scan
  logic [omss_pkg::AddrW-1:0] raddr_q;
  logic [omss_pkg::OccW-1:0] issued_q, seen_q;
  omss_pkg::entry_t best_q;
  logic [omss_pkg::AddrW-1:0] best_idx_q;
  logic stop_q;

  // memory write/read
  logic we;
  logic [omss_pkg::AddrW-1:0] waddr;
  omss_pkg::entry_t wdata, rdata;
  logic [omss_pkg::AddrW-1:0] raddr;

  omss_ram #(
    .Depth(omss_pkg::QueueDepth),
    .Width(omss_pkg::EntryW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // output register
  logic ovalid_q, ovv_q, olast_q, oempty_q, odrop_q;
  logic [omss_pkg::ValW-1:0] oval_q;
  logic [omss_pkg::SrcW-1:0] osrc_q;
  logic out_free;
  assign out_free = !ovalid_q || out_ready_i;

  logic out_load;
  assign out_load = out_free && ((state_q == StEmit) || (state_q == StStatus));

  logic [omss_pkg::CfgW-1:0] nact;
  always_comb begin
    if (active_q == '0) nact = omss_pkg::CfgW'(1);
    else if (active_q > omss_pkg::CfgW'(omss_pkg::Sources))
      nact = omss_pkg::CfgW'(omss_pkg::Sources);
    else nact = active_q;
  end

  logic allowed;
  always_comb begin
    allowed = 1'b1;
    for (int i = 0; i < omss_pkg::Sources; i++) begin
      if ((omss_pkg::CfgW'(i) < nact) && pend_q[i] == '0 && !fin_q[i]) allowed = 1'b0;
    end
  end

  logic accept;
  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;

  logic in_act, push_ok;
  assign in_act  = ({1'b0, source_i} < nact);
  assign push_ok = in_act && (action_i == omss_pkg::ActPush) &&
                   (occ_q < omss_pkg::OccW'(omss_pkg::QueueDepth));

  logic [omss_pkg::OccW-1:0] occ_m1;
  assign occ_m1 = occ_q - omss_pkg::OccW'(1);

  always_comb begin
    we    = 1'b0;
    waddr = occ_q[omss_pkg::AddrW-1:0];
    wdata = '{src: source_i, val: value_i};
    raddr = raddr_q;
    if (state_q == StIdle) begin
      we = accept && push_ok;
    end else if (state_q == StCheck) begin
      raddr = occ_m1[omss_pkg::AddrW-1:0];
    end else if (state_q == StPop) begin
      // move the tail entry into the hole; rdata holds the tail
      we    = 1'b1;
      waddr = best_idx_q;
      wdata = rdata;
    end
  end

  logic [omss_pkg::CntW-1:0] bsrc_cnt;
  assign bsrc_cnt = pend_q[best_q.src];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      active_q   <= omss_pkg::CfgW'(2);
      occ_q      <= '0;
      fin_q      <= '0;
      for (int i = 0; i < omss_pkg::Sources; i++) pend_q[i] <= '0;
      dropped_q  <= 1'b0;
      nrel_q     <= '0;
      raddr_q    <= '0;
      issued_q   <= '0;
      seen_q     <= '0;
      best_q     <= '0;
      best_idx_q <= '0;
      stop_q     <= 1'b0;
      ovalid_q   <= 1'b0;
      ovv_q      <= 1'b0;
      oval_q     <= '0;
      osrc_q     <= '0;
      olast_q    <= 1'b0;
      oempty_q   <= 1'b0;
      odrop_q    <= 1'b0;
    end else begin
      if (out_load) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (cfg_valid_i) active_q <= cfg_data_i;
          if (accept) begin
            dropped_q <= in_act && (action_i == omss_pkg::ActPush) && !push_ok;
            if (in_act && action_i == omss_pkg::ActFinish) fin_q[source_i] <= 1'b1;
            if (push_ok) begin
              occ_q <= occ_q + omss_pkg::OccW'(1);
              pend_q[source_i] <= pend_q[source_i] + omss_pkg::CntW'(1);
            end
            nrel_q <= '0;
            stop_q <= 1'b0;
            state_q <= StCheck;
          end
        end
        StCheck: begin
          if (allowed && occ_q != '0) begin
            seen_q   <= '0;
            raddr_q  <= '0;
            issued_q <= '0;
            state_q  <= StScan;
          end else begin
            state_q <= StStatus;
          end
        end
        StScan: begin
          // one read issued per cycle; data arrives next cycle
          if (issued_q < occ_q) begin
            raddr_q  <= raddr_q + omss_pkg::AddrW'(1);
            issued_q <= issued_q + omss_pkg::OccW'(1);
          end else begin
            raddr_q <= occ_m1[omss_pkg::AddrW-1:0];
          end
          if (issued_q != '0 && seen_q < occ_q) begin
            if (seen_q == '0 || omss_pkg::entry_better(rdata, best_q)) begin
              best_q     <= rdata;
              best_idx_q <= seen_q[omss_pkg::AddrW-1:0];
            end
            seen_q <= seen_q + omss_pkg::OccW'(1);
          end else if (seen_q == occ_q) begin
            state_q <= StPop; // tail read is in flight now
          end
        end
        StPop: begin
          occ_q  <= occ_m1;
          nrel_q <= nrel_q + omss_pkg::RelW'(1);
          if (bsrc_cnt != '0) pend_q[best_q.src] <= bsrc_cnt - omss_pkg::CntW'(1);
          stop_q <= (bsrc_cnt <= omss_pkg::CntW'(1)) && !fin_q[best_q.src];
          state_q <= StEmit;
        end
        StEmit: begin
          if (out_free) begin
            ovv_q    <= 1'b1;
            oval_q   <= best_q.val;
            osrc_q   <= best_q.src;
            if (stop_q || occ_q == '0 ||
                nrel_q == omss_pkg::RelW'(omss_pkg::MaxResults)) begin
              olast_q  <= 1'b1;
              oempty_q <= (occ_q == '0);
              odrop_q  <= dropped_q;
              state_q  <= StIdle;
            end else begin
              olast_q  <= 1'b0;
              oempty_q <= 1'b0;
              odrop_q  <= 1'b0;
              seen_q   <= '0;
              raddr_q  <= '0;
              issued_q <= '0;
              state_q  <= StScan;
            end
          end
        end
        StStatus: begin
          if (out_free) begin
            ovv_q    <= 1'b0;
            oval_q   <= '0;
            osrc_q   <= '0;
            olast_q  <= 1'b1;
            oempty_q <= (occ_q == '0);
            odrop_q  <= dropped_q;
            state_q  <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o       = ovalid_q;
  assign value_valid_o     = ovv_q;
  assign released_value_o  = oval_q;
  assign released_source_o = osrc_q;
  assign last_o            = olast_q;
  assign queue_empty_o     = oempty_q;
  assign dropped_o         = odrop_q;

endmodule

FILE: sv/omss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omss_checker
// Port-level checks for the ordered merge block.
// ----------------------------------------------------------------------------
module omss_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic value_valid_o,
  input logic last_o,
  input logic queue_empty_o,
  input logic dropped_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_status_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !queue_empty_o && !dropped_o)
    else $error("status on non-last item");

  a_novalue_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !value_valid_o |-> last_o)
    else $error("empty item that is not last");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted while busy");

endmodule

bind ordered_merge_of_sorted_sources omss_checker u_omss_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .value_valid_o(value_valid_o),
  .last_o(last_o), .queue_empty_o(queue_empty_o), .dropped_o(dropped_o)
);
